>>> rtl/multi_car_elevator_dispatcher_defines.svh
// assertion helpers shared by the dispatcher rtl
`ifndef MULTI_CAR_ELEVATOR_DISPATCHER_DEFINES_SVH
`define MULTI_CAR_ELEVATOR_DISPATCHER_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define MCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define MCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mcd_pkg.sv
`default_nettype none
package mcd_pkg;

	// shaft and group size
	localparam int FLOORS  = 16;
	localparam int CARS    = 8;
	localparam int FLOOR_W = 4;
	localparam int CAR_W   = 3;
	localparam int SLOT_W  = FLOOR_W + 1;

	// register indexes on the configuration port
	localparam logic REG_FLOORS = 1'b0;
	localparam logic REG_CARS   = 1'b1;

	// input item kinds
	localparam logic MODE_PRESS = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	// car heading codes
	localparam logic signed [1:0] HEAD_DOWN = 2'sb11;
	localparam logic signed [1:0] HEAD_IDLE = 2'sb00;
	localparam logic signed [1:0] HEAD_UP   = 2'sb01;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STEP
	} state_t;

	// outcome of moving one car by one floor
	typedef struct packed {
		logic                     arrive;
		logic [FLOOR_W-1:0]       new_pos;
		logic signed [1:0]        new_heading;
		logic [FLOORS-1:0]        new_target;
	} step_res_t;

endpackage
`default_nettype wire

>>> rtl/mcd_car_step.sv
`default_nettype none
module mcd_car_step import mcd_pkg::*; (
	input  wire logic [FLOOR_W-1:0] pos,
	input  wire logic signed [1:0]  head,
	input  wire logic [FLOORS-1:0]  tgt,
	output step_res_t               res
);

	logic [FLOOR_W:0]    nxt;
	logic [FLOORS-1:0]   cleared;

	// one floor up or down, the top bit flags leaving the shaft
	assign nxt     = {1'b0, pos} + {{(FLOOR_W-1){head[1]}}, head};
	assign cleared = tgt & ~(FLOORS'(1) << nxt[FLOOR_W-1:0]);

	// move, stop at the shaft edge, arrive at a target, or go idle once no target is left
	always_comb begin
		res.arrive      = 1'b0;
		res.new_pos     = pos;
		res.new_heading = head;
		res.new_target  = tgt;
		if (head != HEAD_IDLE) begin
			if (nxt[FLOOR_W]) begin
				res.new_heading = HEAD_IDLE;
				res.new_target  = '0;
			end else begin
				res.new_pos = nxt[FLOOR_W-1:0];
				if (tgt[nxt[FLOOR_W-1:0]]) begin
					res.arrive     = 1'b1;
					res.new_target = cleared;
					if (cleared == '0)
						res.new_heading = HEAD_IDLE;
				end else if (tgt == '0) begin
					res.new_heading = HEAD_IDLE;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/multi_car_elevator_dispatcher.sv
// channel   dir  signals                        contents
// s         in   s_tvalid s_tready s_tdata      press or tick, kind in s_tuser
// m         out  m_tvalid m_tready m_tdata      one car status, m_tlast on final car
// cfg       in   cfg_we cfg_index cfg_data      floors_in_use, cars_in_use
//
// a press is accepted in idle; a tick scans two call slots per floor in use, then steps each car in use
// the hall call scan runs one call slot per cycle, then one car steps per cycle while m is not stalled
// a stalled status holds the car step sequencer; s_tready is low until the tick is done
// reset clears all calls, parks all cars idle at floor 0, registers to 10 floors, 3 cars
`default_nettype none
`include "multi_car_elevator_dispatcher_defines.svh"
module multi_car_elevator_dispatcher import mcd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // call_floor[3:0], want_up[4], zero fill
	input  wire logic [0:0]  s_tuser,   // mode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // car_index[2:0], car_floor[6:3], car_heading[8:7],
	                                    // door_open[9], zero fill
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data
);

	state_t state_q, state_d;

	logic [4:0]               fiu_q;
	logic [3:0]               ciu_q;
	logic [1:0]               pend_q  [FLOORS];
	logic [1:0]               owned_q [FLOORS];
	logic [CAR_W-1:0]         owner_q [FLOORS][2];
	logic [FLOOR_W-1:0]       pos_q   [CARS];
	logic signed [1:0]        head_q  [CARS];
	logic [FLOORS-1:0]        tgt_q   [CARS];
	logic [CARS-1:0]          door_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [CAR_W-1:0]         car_q;
	logic                     m_valid_q;
	logic [15:0]              m_data_q;
	logic                     m_last_q;

	logic [4:0]               nfl;
	logic [3:0]               ncars;
	logic [5:0]               slot_end_w;
	logic [SLOT_W-1:0]        last_slot;
	logic [3:0]               car_end_w;
	logic [CAR_W-1:0]         last_car_idx;
	logic [FLOOR_W-1:0]       scan_floor;
	logic                     scan_dir;
	logic [FLOOR_W-1:0]       floor_addr;
	logic [1:0]               pend_row;
	logic [1:0]               owned_row;
	logic [CAR_W-1:0]         owner_row [2];
	logic                     pick_found;
	logic [CAR_W-1:0]         pick;
	logic [CAR_W-1:0]         car_sel;
	logic [FLOOR_W-1:0]       sel_pos;
	logic                     scan_hit;
	logic                     serve_here;
	logic                     step_go;
	logic                     in_acc;
	logic [FLOOR_W-1:0]       in_floor;
	logic                     in_up;
	step_res_t                sr;
	logic                     idle_clear_ok;
	logic                     owned_pend_ok;

	// effective register values, saturated into range
	always_comb begin
		if (fiu_q < 5'd2)
			nfl = 5'd2;
		else if (fiu_q > 5'(FLOORS))
			nfl = 5'(FLOORS);
		else
			nfl = fiu_q;
		if (ciu_q < 4'd1)
			ncars = 4'd1;
		else if (ciu_q > 4'(CARS))
			ncars = 4'(CARS);
		else
			ncars = ciu_q;
	end

	assign slot_end_w   = {nfl, 1'b0} - 6'd1;
	assign last_slot    = slot_end_w[SLOT_W-1:0];
	assign car_end_w    = ncars - 4'd1;
	assign last_car_idx = car_end_w[CAR_W-1:0];

	// handshakes
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_floor = s_tdata[3:0];
	assign in_up    = s_tdata[4];
	assign step_go  = (state_q == ST_STEP) && (!m_valid_q || m_tready);

	// lowest-numbered idle active car
	always_comb begin
		pick_found = 1'b0;
		pick       = '0;
		for (int c = CARS - 1; c >= 0; c--) begin
			if ((4'(c) < ncars) && (head_q[c] == HEAD_IDLE)) begin
				pick_found = 1'b1;
				pick       = CAR_W'(c);
			end
		end
	end

	// one car read port, shared by dispatch and the car step
	assign car_sel = (state_q == ST_STEP) ? car_q : pick;
	assign sel_pos = pos_q[car_sel];

	mcd_car_step u_step (
		.pos  (sel_pos),
		.head (head_q[car_sel]),
		.tgt  (tgt_q[car_sel]),
		.res  (sr)
	);

	// one floor read port, shared by the scan and the arrival clear
	assign scan_floor   = slot_q[SLOT_W-1:1];
	assign scan_dir     = slot_q[0];
	assign floor_addr   = (state_q == ST_STEP) ? sr.new_pos : scan_floor;
	assign pend_row     = pend_q[floor_addr];
	assign owned_row    = owned_q[floor_addr];
	assign owner_row[0] = owner_q[floor_addr][0];
	assign owner_row[1] = owner_q[floor_addr][1];

	assign scan_hit   = (state_q == ST_SCAN) && pend_row[scan_dir] && !owned_row[scan_dir]
	                    && pick_found;
	assign serve_here = scan_hit && (sel_pos == scan_floor);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_tuser[0] == MODE_TICK))
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (slot_q == last_slot)
					state_d = ST_STEP;
			end
			ST_STEP: begin
				if (step_go && (car_q == last_car_idx))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// call, car and output state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q     <= 5'd10;
			ciu_q     <= 4'd3;
			door_q    <= '0;
			slot_q    <= '0;
			car_q     <= '0;
			m_valid_q <= 1'b0;
			for (int f = 0; f < FLOORS; f++) begin
				pend_q[f]  <= '0;
				owned_q[f] <= '0;
			end
			for (int c = 0; c < CARS; c++) begin
				pos_q[c]  <= '0;
				head_q[c] <= HEAD_IDLE;
				tgt_q[c]  <= '0;
			end
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_FLOORS: fiu_q <= cfg_data;
					REG_CARS:   ciu_q <= cfg_data[3:0];
					default:    ;
				endcase
			end

			// output register drains
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser[0] == MODE_TICK) begin
							slot_q <= '0;
							door_q <= '0;
						end else if ({1'b0, in_floor} < nfl) begin
							pend_q[in_floor][in_up] <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					slot_q <= slot_q + 1'b1;
					car_q  <= '0;
					if (serve_here) begin
						pend_q[scan_floor][scan_dir]  <= 1'b0;
						owned_q[scan_floor][scan_dir] <= 1'b0;
						door_q[pick]                  <= 1'b1;
					end else if (scan_hit) begin
						tgt_q[pick][scan_floor]       <= 1'b1;
						head_q[pick]                  <= (sel_pos > scan_floor) ? HEAD_DOWN
						                                                        : HEAD_UP;
						owned_q[scan_floor][scan_dir] <= 1'b1;
					end
				end
				ST_STEP: begin
					if (step_go) begin
						car_q         <= car_q + 1'b1;
						pos_q[car_q]  <= sr.new_pos;
						head_q[car_q] <= sr.new_heading;
						tgt_q[car_q]  <= sr.new_target;
						if (sr.arrive) begin
							for (int d = 0; d < 2; d++) begin
								if (owned_row[d] && (owner_row[d] == car_q)) begin
									pend_q[sr.new_pos][d]  <= 1'b0;
									owned_q[sr.new_pos][d] <= 1'b0;
								end
							end
						end
						m_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// call owner and status payload
	always_ff @(posedge clk) begin
		if (scan_hit && !serve_here)
			owner_q[scan_floor][scan_dir] <= pick;
		if (step_go) begin
			m_data_q <= {6'd0, door_q[car_q] | sr.arrive, sr.new_heading, sr.new_pos, car_q};
			m_last_q <= (car_q == last_car_idx);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	// invariants over all cars and all calls
	always_comb begin
		idle_clear_ok = 1'b1;
		for (int c = 0; c < CARS; c++) begin
			if ((head_q[c] == HEAD_IDLE) && (tgt_q[c] != '0))
				idle_clear_ok = 1'b0;
		end
		owned_pend_ok = 1'b1;
		for (int f = 0; f < FLOORS; f++) begin
			if ((owned_q[f] & ~pend_q[f]) != 2'b00)
				owned_pend_ok = 1'b0;
		end
	end

	`MCD_ASSERT_IMP(a_idle_no_target, 1'b1, idle_clear_ok, "idle car holds a target")
	`MCD_ASSERT_IMP(a_owned_pending, 1'b1, owned_pend_ok, "owned call is not pending")
	`MCD_ASSERT_IMP(a_scan_bound, state_q == ST_SCAN, slot_q <= last_slot, "scan past floors")
	`MCD_ASSERT_NXT(a_tick_starts_scan, in_acc && (s_tuser[0] == MODE_TICK),
		(state_q == ST_SCAN) && (slot_q == '0), "tick did not start the scan")

endmodule
`default_nettype wire
